>>> rtl/sfbc_pkg.sv
// Shared types and constants for the S-box Feistel block cipher.
// No dependencies; imported by the controller, datapath and top level.
package sfbc_pkg;

  localparam int unsigned MODE_BITS  = 2;
  localparam int unsigned TBL_BITS   = 4;   // 16 round tables
  localparam int unsigned BYTE_BITS  = 8;   // 256 entries per table
  localparam int unsigned ADDR_BITS  = TBL_BITS + BYTE_BITS;
  localparam int unsigned MEM_DEPTH  = 1 << ADDR_BITS;
  localparam int unsigned HALF_BITS  = 32;
  localparam int unsigned BLOCK_BITS = 64;

  // Item modes
  localparam logic [MODE_BITS-1:0] MODE_LOAD = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_ENC  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_DEC  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic                blk_load;  // capture data_block into L/R
    logic                mem_wr;    // write one table entry
    logic                rd_en;     // issue one table lookup
    logic [1:0]          phase;     // lookup number within a round
    logic                fold;      // close previous round: (L,R) <- (R, L^F)
    logic [TBL_BITS-1:0] tbl;       // table used by this round
    logic                res_load;  // capture the finished block
  } cmd_t;

endpackage

>>> rtl/sfbc_ctrl.sv
// Controller for the S-box Feistel block cipher: state machine, round and
// lookup counters, output valid. Depends on sfbc_pkg.
module sfbc_ctrl
  import sfbc_pkg::*;
#(
  parameter int unsigned ROUNDS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_BITS-1:0] mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cmd_t                 cmd
);

  localparam logic [TBL_BITS-1:0] LAST_RND = TBL_BITS'(ROUNDS - 1);

  state_t              state, state_next;
  logic [TBL_BITS-1:0] rnd;
  logic [1:0]          phase;
  logic                dec;
  logic                last_rnd;
  logic                is_block;

  assign last_rnd = (rnd == LAST_RND);

  always_comb begin
    case (mode)
      MODE_ENC, MODE_DEC: is_block = 1'b1;
      default:            is_block = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && is_block) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (phase == 2'd3 && last_rnd) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    cmd.tbl  = dec ? (LAST_RND - rnd) : rnd;
    cmd.phase = phase;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.blk_load = in_valid && is_block;
        cmd.mem_wr   = in_valid && (mode == MODE_LOAD);
      end
      ST_RUN: begin
        cmd.rd_en = 1'b1;
        cmd.fold  = (phase == 2'd0) && (rnd != '0);
      end
      ST_FINISH: begin
        cmd.res_load = !out_valid || out_ready;
      end
      default: ;
    endcase
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rnd       <= '0;
      phase     <= '0;
      dec       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.blk_load) begin
        rnd   <= '0;
        phase <= '0;
        dec   <= (mode == MODE_DEC);
      end else if (state == ST_RUN) begin
        phase <= phase + 2'd1;
        if (phase == 2'd3) rnd <= rnd + 1'b1;
      end
      if (cmd.res_load)   out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // A write and a lookup never share the single memory port
  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.mem_wr && cmd.rd_en))
    else $error("table write and lookup in the same cycle");

  // Round counter never runs past the last round while busy
  a_rnd_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (rnd <= LAST_RND))
    else $error("round counter out of range");

  // Lookups step through the four phases in order
  a_phase_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && !(phase == 2'd3 && last_rnd)) |=>
      (state == ST_RUN && phase == $past(phase) + 2'd1))
    else $error("lookup phase skipped");

  // A finished block always shows up on the output
  a_res_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |=> out_valid)
    else $error("result captured but not presented");

endmodule

>>> rtl/sfbc_dpath.sv
// Datapath for the S-box Feistel block cipher: table memory, L/R halves,
// lookup index chain and result register. Depends on sfbc_pkg.
module sfbc_dpath
  import sfbc_pkg::*;
(
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  logic [TBL_BITS-1:0]   table_select,
  input  logic [BYTE_BITS-1:0]  table_entry,
  input  logic [BYTE_BITS-1:0]  table_value,
  input  logic [BLOCK_BITS-1:0] data_block,
  output logic [BLOCK_BITS-1:0] result_block
);

  logic [BYTE_BITS-1:0] mem [MEM_DEPTH];
  logic [BYTE_BITS-1:0] rdata;
  logic [HALF_BITS-1:0] lh, rh;
  logic [23:0]          fbuf;   // first three bytes of F
  logic [BYTE_BITS-1:0] acc;    // running lookup index
  logic [HALF_BITS-1:0] f_full;
  logic [HALF_BITS-1:0] r_cur;
  logic [BYTE_BITS-1:0] idx;
  logic [ADDR_BITS-1:0] addr;

  assign f_full = {fbuf, rdata};
  // Right half of the round; on the first lookup of each later round it is L ^ F,
  // with the last byte of F taken straight from the table read
  assign r_cur  = cmd.fold ? (lh ^ f_full) : rh;

  // Index chain: the first index is the low byte of R; each later one adds the next byte of R, mod 256
  always_comb begin
    case (cmd.phase)
      2'd0:    idx = r_cur[7:0];
      2'd1:    idx = acc + rh[15:8];
      2'd2:    idx = acc + rh[23:16];
      2'd3:    idx = acc + rh[31:24];
      default: idx = r_cur[7:0];
    endcase
  end

  assign addr = cmd.mem_wr ? {table_select, table_entry} : {cmd.tbl, idx};

  // Single-port table memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[addr] <= table_value;
    else if (cmd.rd_en) rdata <= mem[addr];
  end

  // Halves, index and F collection
  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      lh <= data_block[63:32];
      rh <= data_block[31:0];
    end else if (cmd.fold) begin
      lh <= rh;
      rh <= r_cur;
    end
    if (cmd.rd_en) begin
      acc <= idx;
      case (cmd.phase)
        2'd1:    fbuf[23:16] <= rdata;
        2'd2:    fbuf[15:8]  <= rdata;
        2'd3:    fbuf[7:0]   <= rdata;
        default: ;
      endcase
    end
    // Final swap folded in: output is (L ^ F) || R
    if (cmd.res_load) result_block <= {lh ^ f_full, rh};
  end

endmodule

>>> rtl/sbox_feistel_block_cipher.sv
// A block runs ROUNDS rounds of four chained lookups on one table port, then its
// result is registered, held back while an earlier result is still unread; no new
// item is taken until the block is done. Table entries are written while idle.
// Reset clears the controller and output valid; the tables hold no defined value
// until loaded.
module sbox_feistel_block_cipher
  import sfbc_pkg::*;
#(
  parameter int unsigned ROUNDS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_BITS-1:0]  mode,
  input  logic [TBL_BITS-1:0]   table_select,
  input  logic [BYTE_BITS-1:0]  table_entry,
  input  logic [BYTE_BITS-1:0]  table_value,
  input  logic [BLOCK_BITS-1:0] data_block,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BLOCK_BITS-1:0] result_block
);

  cmd_t cmd;

  sfbc_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  sfbc_dpath u_dpath (
    .clk         (clk),
    .cmd         (cmd),
    .table_select(table_select),
    .table_entry (table_entry),
    .table_value (table_value),
    .data_block  (data_block),
    .result_block(result_block)
  );

endmodule
